/* rtl/grid_atlas_rectangle_allocator_assert.svh */
// ---------------------------------------------------------------------------
// Grid atlas allocator assertion macros
// Clocked implication checks with the reset disable built in.
// ---------------------------------------------------------------------------
`ifndef GRID_ATLAS_RECTANGLE_ALLOCATOR_ASSERT_SVH
`define GRID_ATLAS_RECTANGLE_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GAA_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid atlas allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define GAA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid atlas allocator check failed");

`endif

/* rtl/gaa_pkg.sv */
// ---------------------------------------------------------------------------
// gaa_pkg
// Item types, status and command codes for the grid atlas allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gaa_pkg;

    localparam int PIX_W    = 16;
    localparam int ID_W     = 16;
    localparam int OFFSET_W = 12;
    // Cell counts up to the largest supported grid (256) fit in 9 bits
    localparam int SIZE_W   = 9;

    // Commands
    localparam logic CMD_CLEAR = 1'b0;

    // Result status codes
    localparam logic [1:0] STATUS_PLACED     = 2'd0;
    localparam logic [1:0] STATUS_STANDALONE = 2'd1;
    localparam logic [1:0] STATUS_DEFERRED   = 2'd2;
    localparam logic [1:0] STATUS_CLEARED    = 2'd3;

    typedef struct packed {
        logic             command;
        logic [ID_W-1:0]  texture_id;
        logic [PIX_W-1:0] pixel_width;
        logic [PIX_W-1:0] pixel_height;
    } gaa_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_W-1:0]     result_id;
        logic [OFFSET_W-1:0] offset_x;
        logic [OFFSET_W-1:0] offset_y;
    } gaa_rsp_t;

    // Request size decoded into cells
    typedef struct packed {
        logic              standalone;
        logic [SIZE_W-1:0] width_cells;
        logic [SIZE_W-1:0] height_cells;
    } gaa_size_t;

endpackage

/* rtl/gaa_size_decode.sv */
// ---------------------------------------------------------------------------
// gaa_size_decode
// Converts a request's pixel size into grid cells and flags sizes that
// cannot go into the atlas (not a power of two, or larger than the grid).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaa_size_decode
    import gaa_pkg::*;
#(
    parameter int GRID_CELLS  = 128,
    parameter int CELL_PIXELS = 32
)
(
    input  logic [PIX_W-1:0] pixel_width,
    input  logic [PIX_W-1:0] pixel_height,
    output gaa_size_t        size
);

    localparam int LOG_W = $clog2(PIX_W);

    logic [SIZE_W-1:0] tab_cells [PIX_W];
    logic              tab_big   [PIX_W];

    logic [PIX_W-1:0]  side_px    [2];
    logic [LOG_W-1:0]  side_pos   [2];
    logic              side_pow2  [2];
    logic              side_zero  [2];
    logic [SIZE_W-1:0] side_cells [2];
    logic              side_big   [2];

    // Cell count for each power of two, fixed at elaboration
    for (genvar k = 0; k < PIX_W; k++) begin : g_tab
        localparam int unsigned QUOT = (32'd1 << k) / CELL_PIXELS;
        assign tab_cells[k] = (QUOT > GRID_CELLS) ? SIZE_W'(0) : SIZE_W'(QUOT);
        assign tab_big[k]   = (QUOT > GRID_CELLS);
    end

    // Per side: power-of-two test, bit position, table lookup
    always_comb
    begin
        side_px[0] = pixel_width;
        side_px[1] = pixel_height;
        for (int s = 0; s < 2; s++)
        begin
            side_pos[s] = '0;
            for (int b = 0; b < PIX_W; b++)
            begin
                if (side_px[s][b])
                begin
                    side_pos[s] = side_pos[s] | LOG_W'(b);
                end
            end
            side_pow2[s]  = ((side_px[s] & (side_px[s] - PIX_W'(1))) == '0);
            side_zero[s]  = (side_px[s] == '0);
            side_cells[s] = side_zero[s] ? '0 : tab_cells[side_pos[s]];
            side_big[s]   = !side_zero[s] && tab_big[side_pos[s]];
        end
        size.standalone   = !side_pow2[0] || !side_pow2[1] || side_big[0] || side_big[1];
        size.width_cells  = side_cells[0];
        size.height_cells = side_cells[1];
    end

endmodule

/* rtl/grid_atlas_rectangle_allocator.sv */
// ---------------------------------------------------------------------------
// grid_atlas_rectangle_allocator
// Packs rectangles into a square atlas tracked as a grid of occupancy cells.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) takes one command item: clear
//   the atlas or place a rectangle. rsp channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one result item per request.
//   Occupancy lives in a row-wide synchronous RAM, GRID_CELLS rows of
//   GRID_CELLS bits. One item is worked on at a time; req_stall is high
//   until the item's work is done.
//   Work per item: standalone or deferred-while-exhausted requests go
//   straight to the result. A clear sweeps every row. A placement scans
//   cells from the cursor, reading each RAM row the scan reaches, then
//   marks each covered row (read, merge-write); a scan across the whole
//   grid is the worst case.
//   Reset: the RAM is cleared by a sweep of every row with req_stall
//   high; cursor at the origin, atlas not exhausted.
//   Stall: a finished result sits in the output register while the next
//   request is already being worked; only when a second result is ready
//   with the first still stalled does the block wait.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_atlas_rectangle_allocator_assert.svh"

module grid_atlas_rectangle_allocator
    import gaa_pkg::*;
#(
    parameter int GRID_CELLS  = 128,
    parameter int CELL_PIXELS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  gaa_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output gaa_rsp_t rsp
);

    localparam int RW    = $clog2(GRID_CELLS);
    localparam int CNT_W = $clog2(GRID_CELLS + 1);
    localparam int EXT_W = CNT_W + 1;
    localparam int PROD_W = RW + SIZE_W;
    localparam logic [RW-1:0]    LAST     = RW'(GRID_CELLS - 1);
    localparam logic [EXT_W-1:0] GRID_EXT = EXT_W'(GRID_CELLS);
    localparam logic [SIZE_W-1:0] CELL_PX = SIZE_W'(CELL_PIXELS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MARK_RD,
        S_MARK_WR,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [RW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                clr_reply_reg, clr_reply_next;
    logic [RW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                exhausted_reg, exhausted_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [CNT_W-1:0]    tw_reg, tw_next;
    logic [CNT_W-1:0]    th_reg, th_next;
    logic [RW-1:0]       mark_col_reg, mark_col_next;
    logic [RW-1:0]       mark_row_reg, mark_row_next;
    logic [RW-1:0]       mark_last_reg, mark_last_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [OFFSET_W-1:0] res_x_reg, res_x_next;
    logic [OFFSET_W-1:0] res_y_reg, res_y_next;
    logic                rsp_valid_reg, rsp_valid_next;
    gaa_rsp_t            rsp_reg, rsp_next;

    gaa_size_t           size;

    // Occupancy RAM
    logic [GRID_CELLS-1:0] row_mem [GRID_CELLS];
    logic [GRID_CELLS-1:0] rd_row_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [RW-1:0]         mem_waddr;
    logic [RW-1:0]         mem_raddr;
    logic [GRID_CELLS-1:0] mem_wdata;
    logic [GRID_CELLS-1:0] mark_mask;

    logic [EXT_W-1:0]      col_ext, row_ext, tw_ext, th_ext;
    logic [EXT_W-1:0]      col_sum, row_sum;
    logic [EXT_W-1:0]      mask_lo, mask_hi;

    gaa_size_decode #(
        .GRID_CELLS  (GRID_CELLS),
        .CELL_PIXELS (CELL_PIXELS)
    ) u_size (
        .pixel_width  (req.pixel_width),
        .pixel_height (req.pixel_height),
        .size         (size)
    );

    // Row RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_row_reg <= row_mem[mem_raddr];
        end
    end

    // Cursor arithmetic
    assign col_ext = EXT_W'(col_reg);
    assign row_ext = EXT_W'(row_reg);
    assign tw_ext  = EXT_W'(tw_reg);
    assign th_ext  = EXT_W'(th_reg);
    assign col_sum = col_ext + tw_ext;
    assign row_sum = row_ext + th_ext;

    // Columns covered by the rectangle in the row being marked
    assign mask_lo = EXT_W'(mark_col_reg);
    assign mask_hi = EXT_W'(mark_col_reg) + tw_ext;

    always_comb
    begin
        for (int i = 0; i < GRID_CELLS; i++)
        begin
            mark_mask[i] = (EXT_W'(i) >= mask_lo) && (EXT_W'(i) < mask_hi);
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        exhausted_next  = exhausted_reg;
        id_next         = id_reg;
        tw_next         = tw_reg;
        th_next         = th_reg;
        mark_col_next   = mark_col_reg;
        mark_row_next   = mark_row_reg;
        mark_last_next  = mark_last_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_raddr       = row_reg;
        mem_wdata       = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == LAST)
                begin
                    state_next = clr_reply_reg ? S_FINISH : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + RW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    id_next    = req.texture_id;
                    tw_next    = size.width_cells[CNT_W-1:0];
                    th_next    = size.height_cells[CNT_W-1:0];
                    res_x_next = '0;
                    res_y_next = '0;
                    if (req.command == CMD_CLEAR)
                    begin
                        col_next        = '0;
                        row_next        = '0;
                        exhausted_next  = 1'b0;
                        clr_cnt_next    = '0;
                        clr_reply_next  = 1'b1;
                        res_status_next = STATUS_CLEARED;
                        state_next      = S_CLEAR;
                    end
                    else if (size.standalone)
                    begin
                        res_status_next = STATUS_STANDALONE;
                        state_next      = S_FINISH;
                    end
                    else if (exhausted_reg)
                    begin
                        res_status_next = STATUS_DEFERRED;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = row_reg;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (!rd_row_reg[col_reg])
                begin
                    // Free cell under the cursor
                    if ((row_sum > GRID_EXT) || (col_sum > GRID_EXT))
                    begin
                        res_status_next = STATUS_DEFERRED;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        res_status_next = STATUS_PLACED;
                        res_x_next      = OFFSET_W'(PROD_W'(col_reg) * PROD_W'(CELL_PX));
                        res_y_next      = OFFSET_W'(PROD_W'(row_reg) * PROD_W'(CELL_PX));
                        mark_col_next   = col_reg;
                        mark_row_next   = row_reg;
                        mark_last_next  = RW'(row_sum - EXT_W'(1));
                        // Advance the cursor past the rectangle
                        if (col_sum >= GRID_EXT)
                        begin
                            col_next = '0;
                            if (row_reg == LAST)
                            begin
                                row_next       = '0;
                                exhausted_next = 1'b1;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_sum[RW-1:0];
                        end
                        if ((tw_reg == '0) || (th_reg == '0))
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_MARK_RD;
                        end
                    end
                end
                else if (col_reg == LAST)
                begin
                    col_next = '0;
                    if (row_reg == LAST)
                    begin
                        // Scan ran off the last cell
                        row_next        = '0;
                        exhausted_next  = 1'b1;
                        res_status_next = STATUS_DEFERRED;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        row_next   = row_reg + RW'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    col_next = col_reg + RW'(1);
                end
            end

            S_MARK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = mark_row_reg;
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = mark_row_reg;
                mem_wdata = rd_row_reg | mark_mask;
                if (mark_row_reg == mark_last_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mark_row_next = mark_row_reg + RW'(1);
                    state_next    = S_MARK_RD;
                end
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = res_status_reg;
                    rsp_next.result_id = id_reg;
                    rsp_next.offset_x  = res_x_reg;
                    rsp_next.offset_y  = res_y_reg;
                    clr_reply_next     = 1'b0;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_reply_reg  <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            exhausted_reg  <= 1'b0;
            id_reg         <= '0;
            tw_reg         <= '0;
            th_reg         <= '0;
            mark_col_reg   <= '0;
            mark_row_reg   <= '0;
            mark_last_reg  <= '0;
            res_status_reg <= STATUS_PLACED;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_reply_reg  <= clr_reply_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            exhausted_reg  <= exhausted_next;
            id_reg         <= id_next;
            tw_reg         <= tw_next;
            th_reg         <= th_next;
            mark_col_reg   <= mark_col_next;
            mark_row_reg   <= mark_row_next;
            mark_last_reg  <= mark_last_next;
            res_status_reg <= res_status_next;
            res_x_reg      <= res_x_next;
            res_y_reg      <= res_y_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `GAA_ASSERT_HOLDS(a_mem_port_excl, clk, rst_n, mem_we, !mem_re)
    `GAA_ASSERT_HOLDS(a_exhausted_origin, clk, rst_n, exhausted_reg, (col_reg == '0) && (row_reg == '0))
    `GAA_ASSERT_HOLDS(a_offset_zero, clk, rst_n, rsp_valid && (rsp.status != STATUS_PLACED), (rsp.offset_x == '0) && (rsp.offset_y == '0))
    `GAA_ASSERT_NEXT(a_clear_sweep, clk, rst_n, req_valid && !req_stall && (req.command == CMD_CLEAR), state_reg == S_CLEAR)
    `GAA_ASSERT_HOLDS(a_mark_in_range, clk, rst_n, state_reg == S_MARK_WR, mark_row_reg <= mark_last_reg)

endmodule

/* sim/grid_atlas_rectangle_allocator_tb.sv */
// ---------------------------------------------------------------------------
// grid_atlas_rectangle_allocator_tb
// Self-checking bench for the grid atlas allocator. A behavioral model of
// the occupancy grid, cursor and exhaustion flag predicts every result item.
// Directed tests cover size classification, edge overflow and grid
// exhaustion. Random atlases follow, with bursty requests and stalled
// results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_atlas_rectangle_allocator_tb;

    import gaa_pkg::*;

    localparam int GRID_CELLS    = 128;
    localparam int CELL_PIXELS   = 32;
    localparam int RESET_CYCLES  = 6;
    localparam int TOTAL_ITEMS   = 1550;
    // Covers the tallest placement, which marks every row, plus overhead
    localparam int SETTLE_CYCLES = 2 * GRID_CELLS + 16;
    // Full-grid scan per atlas plus worst marking, stall and gap per item,
    // with a wide margin on top
    localparam int CYCLE_LIMIT   = 20_000_000;

    localparam logic CMD_PLACE = ~CMD_CLEAR;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTS} stall_mode_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    gaa_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    gaa_rsp_t rsp;

    // Atlas model state
    bit [GRID_CELLS-1:0] occupied_cells [GRID_CELLS];
    int unsigned         cursor_col;
    int unsigned         cursor_row;
    bit                  atlas_full;

    gaa_rsp_t    expected_results[$];
    gaa_rsp_t    oldest_expected;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned error_count = 0;
    int unsigned atlases_filled = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned cycle_count = 0;

    // Request pacing
    bit          gaps_enabled = 1'b1;
    int unsigned burst_left = 0;

    // Result stall pattern
    stall_mode_t stall_mode = STALL_NONE;
    int unsigned stall_mode_left = 0;
    int unsigned stall_hold = 0;

    grid_atlas_rectangle_allocator #(
        .GRID_CELLS  (GRID_CELLS),
        .CELL_PIXELS (CELL_PIXELS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Atlas model
    // -----------------------------------------------------------------------
    function automatic void empty_atlas();
        foreach (occupied_cells[r])
            occupied_cells[r] = '0;
        cursor_col = 0;
        cursor_row = 0;
        atlas_full = 1'b0;
    endfunction

    function automatic bit is_pow2_or_zero(input logic [PIX_W-1:0] side);
        logic [PIX_W-1:0] less_one;
        less_one = side - 1'b1;
        return (side & less_one) == '0;
    endfunction

    // Applies one request to the model and returns the result it must produce
    function automatic gaa_rsp_t predict_allocation(input gaa_req_t item);
        gaa_rsp_t    outcome;
        int unsigned cols;
        int unsigned rows;
        bit          found;
        outcome = '0;
        outcome.result_id = item.texture_id;
        if (item.command == CMD_CLEAR)
        begin
            empty_atlas();
            outcome.status = STATUS_CLEARED;
            return outcome;
        end
        cols = item.pixel_width / CELL_PIXELS;
        rows = item.pixel_height / CELL_PIXELS;
        // size classification comes before the exhaustion check
        if (!is_pow2_or_zero(item.pixel_width) || !is_pow2_or_zero(item.pixel_height) ||
            cols > GRID_CELLS || rows > GRID_CELLS)
        begin
            outcome.status = STATUS_STANDALONE;
            return outcome;
        end
        outcome.status = STATUS_DEFERRED;
        if (atlas_full)
            return outcome;
        // walk to the first free cell, row-major
        found = 1'b1;
        while (found && occupied_cells[cursor_row][cursor_col])
        begin
            cursor_col++;
            if (cursor_col >= GRID_CELLS)
            begin
                cursor_col = 0;
                cursor_row++;
                if (cursor_row >= GRID_CELLS)
                begin
                    cursor_row = 0;
                    atlas_full = 1'b1;
                    atlases_filled++;
                    found = 1'b0;
                end
            end
        end
        if (!found)
            return outcome;
        // bottom or right edge crossed: cursor keeps the free cell
        if (cursor_row + rows > GRID_CELLS || cursor_col + cols > GRID_CELLS)
            return outcome;
        for (int unsigned r = cursor_row; r < cursor_row + rows; r++)
            for (int unsigned c = cursor_col; c < cursor_col + cols; c++)
                occupied_cells[r][c] = 1'b1;
        outcome.status   = STATUS_PLACED;
        outcome.offset_x = OFFSET_W'(cursor_col * CELL_PIXELS);
        outcome.offset_y = OFFSET_W'(cursor_row * CELL_PIXELS);
        cursor_col += cols;
        if (cursor_col >= GRID_CELLS)
        begin
            cursor_col = 0;
            cursor_row++;
            if (cursor_row >= GRID_CELLS)
            begin
                cursor_row = 0;
                atlas_full = 1'b1;
                atlases_filled++;
            end
        end
        return outcome;
    endfunction

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [ID_W-1:0] id,
                                input logic [PIX_W-1:0] width,
                                input logic [PIX_W-1:0] height);
        gaa_req_t    item;
        int unsigned gap;
        item.command      = cmd;
        item.texture_id   = id;
        item.pixel_width  = width;
        item.pixel_height = height;
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_results.insert(expected_results.size(), predict_allocation(item));
        items_sent++;
        // bursts of back-to-back items separated by idle gaps
        if (gaps_enabled)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 12);
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Hold off new requests until every outstanding result is back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    function automatic logic [PIX_W-1:0] random_side(input int unsigned max_shift);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return '0;
        if (pick < 12)
            return PIX_W'(1) << $urandom_range(0, 4);
        return PIX_W'(CELL_PIXELS) << $urandom_range(0, max_shift);
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_clear_and_degenerate_sizes();
        // clear ignores the size fields
        send_request(CMD_CLEAR, 16'h0000, 16'hFFFF, 16'hFFFF);
        // zero size lands at the cursor and leaves it in place
        send_request(CMD_PLACE, 16'hFFFF, 16'd0, 16'd0);
        // narrower than a cell: no cells covered even at full height
        send_request(CMD_PLACE, 16'h8001, 16'd16, 16'd4096);
        send_request(CMD_PLACE, 16'h1234, 16'd32, 16'd32);
        wait_for_results();
    endtask

    task automatic test_standalone_and_edges();
        send_request(CMD_PLACE, 16'h0101, 16'd3, 16'd32);
        send_request(CMD_PLACE, 16'h0102, 16'd32, 16'hFFFF);
        // power of two but wider than the grid
        send_request(CMD_PLACE, 16'h0103, 16'd8192, 16'd32);
        // cursor at column 1: full width runs off the right edge
        send_request(CMD_PLACE, 16'h0104, 16'd4096, 16'd4096);
        send_request(CMD_CLEAR, 16'h0105, 16'd0, 16'd0);
        // full-width row wraps the cursor to row 1
        send_request(CMD_PLACE, 16'h0106, 16'd4096, 16'd32);
        // full height from row 1 runs off the bottom edge
        send_request(CMD_PLACE, 16'h0107, 16'd32, 16'd4096);
        wait_for_results();
    endtask

    task automatic test_grid_exhaustion();
        send_request(CMD_CLEAR, 16'h0200, 16'd0, 16'd0);
        send_request(CMD_PLACE, 16'h0201, 16'd4096, 16'd4096);
        // scan runs past the last cell: deferred once, grid marked exhausted
        send_request(CMD_PLACE, 16'h0202, 16'd32, 16'd32);
        send_request(CMD_PLACE, 16'h0203, 16'd0, 16'd0);
        // standalone wins over exhaustion
        send_request(CMD_PLACE, 16'h0204, 16'd5, 16'd32);
        wait_for_results();
    endtask

    task automatic test_last_row_wrap();
        send_request(CMD_CLEAR, 16'h0300, 16'd0, 16'd0);
        // full-width bands of halving height fill rows 0..126
        for (int k = 6; k >= 0; k--)
            send_request(CMD_PLACE, ID_W'(16'h0310 + k), 16'd4096, PIX_W'(CELL_PIXELS) << k);
        // last row: placement moves the cursor past the final cell
        send_request(CMD_PLACE, 16'h0320, 16'd4096, 16'd32);
        send_request(CMD_PLACE, 16'h0321, 16'd32, 16'd32);
        wait_for_results();
    endtask

    task automatic test_random_atlases();
        int unsigned seq_len;
        int unsigned max_shift;
        int unsigned pick;
        while (items_sent < TOTAL_ITEMS)
        begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            max_shift = (pick < 4) ? 3 : (pick < 8) ? 5 : 7;
            send_request(CMD_CLEAR, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            seq_len = $urandom_range(4, 40);
            for (int unsigned i = 0; i < seq_len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                    send_request(CMD_PLACE, 16'($urandom_range(0, 65535)),
                                 random_side(max_shift), random_side(max_shift));
                else if (pick < 92)
                    send_request(CMD_PLACE, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
                else if (pick < 96)
                    send_request(CMD_PLACE, 16'($urandom_range(0, 65535)),
                                 PIX_W'(1) << $urandom_range(13, 15),
                                 random_side(max_shift));
                else
                    send_request(CMD_CLEAR, 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // -----------------------------------------------------------------------
    // Result side: stall pattern and checking
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(50, 400);
        end
        else
        begin
            stall_mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:
            begin
                if (stall_hold > 0)
                begin
                    stall_hold--;
                    rsp_stall <= 1'b1;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_hold = $urandom_range(1, 12);
                    rsp_stall <= 1'b1;
                end
                else
                begin
                    rsp_stall <= 1'b0;
                end
            end
        endcase
    end

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: unexpected result item, expected none, got %p",
                         $time, rsp);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                check_field("status", 32'(oldest_expected.status), 32'(rsp.status));
                check_field("result_id", 32'(oldest_expected.result_id),
                            32'(rsp.result_id));
                check_field("offset_x", 32'(oldest_expected.offset_x),
                            32'(rsp.offset_x));
                check_field("offset_y", 32'(oldest_expected.offset_y),
                            32'(rsp.offset_y));
                status_seen[oldest_expected.status]++;
                results_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial
    begin
        empty_atlas();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_clear_and_degenerate_sizes();
        test_standalone_and_edges();
        test_grid_exhaustion();
        test_last_row_wrap();
        test_random_atlases();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t ns: %0d expected results never arrived",
                     $time, expected_results.size());
        end

        $display("Ran %0d items: %0d clears, %0d placed, %0d standalone, %0d deferred.",
                 items_sent, status_seen[STATUS_CLEARED], status_seen[STATUS_PLACED],
                 status_seen[STATUS_STANDALONE], status_seen[STATUS_DEFERRED]);
        $display("%0d atlases filled to exhaustion; %0d results checked under random stalls.",
                 atlases_filled, results_checked);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
